### design/crt_bd_pkg.sv
// ----------------------------------------------------------------------------
// crt_bd_pkg
// shared types, register codes and fixed-point constants of the crt filter
// ----------------------------------------------------------------------------
package crt_bd_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DIM_REG_W  = 11;
	localparam int K_W        = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DISTORTION_K  = 2'd2;

	localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = 11'd800;
	localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = 11'd600;
	localparam logic [K_W-1:0]       K_RESET      = 16'd9830;

	localparam int INV_W = 17;
	localparam int QUO_W = 18;
	localparam logic [QUO_W-1:0] RECIP_NUM = 18'h20000;

	localparam logic [17:0] ONE_Q16      = 18'd65536;
	localparam logic [14:0] VIGNETTE_Q16 = 15'd29491;
	localparam logic [15:0] SCANLINE_Q16 = 16'd36044;
	localparam logic [13:0] LUMA_R_Q16   = 14'd13932;
	localparam logic [15:0] LUMA_G_Q16   = 16'd46871;
	localparam logic [12:0] LUMA_B_Q16   = 13'd4731;
	localparam logic [16:0] GAIN_Q16     = 17'd85196;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	typedef struct packed {
		logic       req_type;
		logic [9:0] pixel_x;
		logic [9:0] pixel_y;
		logic [7:0] src_red;
		logic [7:0] src_green;
		logic [7:0] src_blue;
	} req_t;

	typedef struct packed {
		logic [7:0] out_green;
		logic       mapped;
	} rsp_t;

endpackage

### design/crt_bd_ram.sv
// ----------------------------------------------------------------------------
// crt_bd_ram
// generic single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module crt_bd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

### design/crt_bd_recip.sv
// ----------------------------------------------------------------------------
// crt_bd_recip
// bit-serial restoring divider forming floor(2^17 / divisor)
// ----------------------------------------------------------------------------
module crt_bd_recip #(
	parameter int DW = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [DW-1:0]               divisor,
	output logic                        busy,
	output logic [crt_bd_pkg::INV_W-1:0] quot
);

	logic          run_q;
	logic [4:0]    cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [crt_bd_pkg::QUO_W-1:0] q_q;

	logic [DW:0]   trial;
	logic          ge;
	logic [DW-1:0] nrem;

	always_comb begin
		trial = {rem_q, crt_bd_pkg::RECIP_NUM[cnt_q]};
		ge    = trial >= {1'b0, dvs_q};
		nrem  = ge ? DW'(trial - {1'b0, dvs_q}) : DW'(trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			cnt_q <= 5'(crt_bd_pkg::QUO_W - 1);
		end else if (run_q) begin
			if (cnt_q == '0) begin
				run_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			dvs_q <= divisor;
			q_q   <= '0;
		end else if (run_q) begin
			rem_q <= nrem;
			q_q   <= {q_q[crt_bd_pkg::QUO_W-2:0], ge};
		end
	end

	assign busy = run_q;
	assign quot = q_q[crt_bd_pkg::INV_W-1:0];

endmodule

### design/crt_bd_pipe.sv
// ----------------------------------------------------------------------------
// crt_bd_pipe
// pixel pipeline: coordinate mapping, frame store access and shading
// ----------------------------------------------------------------------------
module crt_bd_pipe #(
	parameter int MAX_WIDTH  = crt_bd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = crt_bd_pkg::MAX_HEIGHT_DEF,
	parameter int WCW        = $clog2(MAX_WIDTH + 1),
	parameter int HCW        = $clog2(MAX_HEIGHT + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  crt_bd_pkg::req_t              req,
	input  logic [WCW-1:0]                w,
	input  logic [HCW-1:0]                h,
	input  logic [crt_bd_pkg::INV_W-1:0]  inv_x,
	input  logic [crt_bd_pkg::INV_W-1:0]  inv_y,
	input  logic [crt_bd_pkg::K_W-1:0]    k,
	output logic                          done,
	output crt_bd_pkg::rsp_t              rsp
);

	localparam int AW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int XAW  = $clog2(MAX_WIDTH);
	localparam int YAW  = $clog2(MAX_HEIGHT);
	localparam int UXW  = 22 + WCW;
	localparam int UYW  = 22 + HCW;

	// valid and type bits; only the valid bits are cleared on reset
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic v_s10, v_s11, v_s12, v_s13;
	logic rd_s1, rd_s2, rd_s3, rd_s4, rd_s5, rd_s6, rd_s7, rd_s8, rd_s9;

	// payload carried along
	logic [9:0]  x_s1, x_s2, x_s3, x_s4, x_s5, x_s6, x_s7, x_s8, x_s9;
	logic [9:0]  y_s1, y_s2, y_s3, y_s4, y_s5, y_s6, y_s7, y_s8, y_s9;
	logic [23:0] rgb_s1, rgb_s2, rgb_s3, rgb_s4, rgb_s5, rgb_s6, rgb_s7, rgb_s8, rgb_s9;
	logic        in_s1, in_s2, in_s3, in_s4, in_s5, in_s6, in_s7, in_s8;

	logic signed [17:0] nx_s1, ny_s1, nx_s2, ny_s2, nx_s3, ny_s3, nx_s4, ny_s4;
	logic signed [17:0] nx_s5, ny_s5;
	logic [32:0] sqx_s2, sqy_s2;
	logic [17:0] r2_s3;
	logic [33:0] kr_s4;
	logic [32:0] vp_s4;
	logic [17:0] dt_s5;
	logic [16:0] vm_s5, vm_s6, vm_s7, vm_s8, vm_s9, vm_s10, vm_s11;
	logic [32:0] vsc_s6;
	logic signed [36:0] px_s6, py_s6;
	logic signed [21:0] ox_s7, oy_s7;
	logic signed [UXW-1:0] ux_s8;
	logic signed [UYW-1:0] uy_s8;
	logic mp_s10, mp_s11, mp_s12, mp_s13;
	logic [23:0] luma_s11;
	logic [24:0] t1_s12;
	logic [25:0] t2_s13;

	logic       done_q;
	crt_bd_pkg::rsp_t rsp_q;

	// stage 1 combinational: normalise coordinates
	logic [27:0] pxi, pyi;
	logic        in_c;
	always_comb begin
		pxi  = 28'(req.pixel_x) * 28'(inv_x);
		pyi  = 28'(req.pixel_y) * 28'(inv_y);
		in_c = (32'(req.pixel_x) < 32'(w)) && (32'(req.pixel_y) < 32'(h));
	end

	logic signed [35:0] sqx_c, sqy_c;
	assign sqx_c = nx_s1 * nx_s1;
	assign sqy_c = ny_s1 * ny_s1;

	logic [33:0] sum_c;
	assign sum_c = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	// stage 7: truncate toward zero, shift into 0..2 range
	logic [36:0] mx_c, my_c;
	logic signed [21:0] sx_c, sy_c;
	always_comb begin
		mx_c = px_s6[36] ? 37'(-px_s6) : 37'(px_s6);
		my_c = py_s6[36] ? 37'(-py_s6) : 37'(py_s6);
		sx_c = px_s6[36] ? -$signed({1'b0, mx_c[36:16]}) : $signed({1'b0, mx_c[36:16]});
		sy_c = py_s6[36] ? -$signed({1'b0, my_c[36:16]}) : $signed({1'b0, my_c[36:16]});
	end

	logic signed [WCW-1:0] hw_c;
	logic signed [HCW-1:0] hh_c;
	assign hw_c = $signed({1'b0, w[WCW-1:1]});
	assign hh_c = $signed({1'b0, h[HCW-1:1]});

	// stage 9: bounds check and frame store access
	logic ok_c, rd_en, wr_en;
	logic [XAW-1:0] sxa_c;
	logic [YAW-1:0] sya_c;
	logic [AW-1:0]  addr_c;
	logic [23:0]    rdata;
	always_comb begin
		ok_c = in_s8 && !ux_s8[UXW-1] && !uy_s8[UYW-1]
			&& ($unsigned(ux_s8) < (UXW'(w) << 16))
			&& ($unsigned(uy_s8) < (UYW'(h) << 16));
		sxa_c = ux_s8[16 +: XAW];
		sya_c = uy_s8[16 +: YAW];
	end

	logic mp_s9;
	logic [XAW-1:0] sxa_s9;
	logic [YAW-1:0] sya_s9;

	always_comb begin
		wr_en = v_s9 && (rd_s9 == crt_bd_pkg::REQ_WRITE)
			&& (32'(x_s9) < MAX_WIDTH) && (32'(y_s9) < MAX_HEIGHT);
		rd_en = v_s9 && (rd_s9 == crt_bd_pkg::REQ_READ) && mp_s9;
		if (wr_en) begin
			addr_c = AW'(32'(y_s9) * MAX_WIDTH + 32'(x_s9));
		end else begin
			addr_c = AW'(32'(sya_s9) * MAX_WIDTH + 32'(sxa_s9));
		end
	end

	crt_bd_ram #(
		.WIDTH(24),
		.DEPTH(MAX_WIDTH * MAX_HEIGHT)
	) u_frame (
		.clk  (clk),
		.en   (rd_en | wr_en),
		.we   (wr_en),
		.addr (addr_c),
		.wdata(rgb_s9),
		.rdata(rdata)
	);

	logic [23:0] luma_c;
	assign luma_c = 24'(24'(crt_bd_pkg::LUMA_R_Q16) * 24'(rdata[23:16])
		+ 24'(crt_bd_pkg::LUMA_G_Q16) * 24'(rdata[15:8])
		+ 24'(crt_bd_pkg::LUMA_B_Q16) * 24'(rdata[7:0]));

	logic [40:0] t1_c;
	logic [41:0] t2_c;
	assign t1_c = 41'(vm_s11) * 41'(luma_s11);
	assign t2_c = 42'(t1_s12) * 42'(crt_bd_pkg::GAIN_Q16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0; v_s12 <= 1'b0;
			v_s13 <= 1'b0; done_q <= 1'b0;
		end else begin
			v_s1  <= accept;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			// writes leave the pipe once stored
			v_s10 <= v_s9 && (rd_s9 == crt_bd_pkg::REQ_READ);
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			done_q <= v_s13;
		end
	end

	always_ff @(posedge clk) begin
		rd_s1  <= req.req_type;
		x_s1   <= req.pixel_x;
		y_s1   <= req.pixel_y;
		rgb_s1 <= {req.src_red, req.src_green, req.src_blue};
		in_s1  <= in_c;
		nx_s1  <= $signed(18'(pxi - 28'(crt_bd_pkg::ONE_Q16)));
		ny_s1  <= $signed(18'(pyi - 28'(crt_bd_pkg::ONE_Q16)));

		rd_s2 <= rd_s1; x_s2 <= x_s1; y_s2 <= y_s1; rgb_s2 <= rgb_s1; in_s2 <= in_s1;
		nx_s2 <= nx_s1; ny_s2 <= ny_s1;
		sqx_s2 <= 33'(sqx_c);
		sqy_s2 <= 33'(sqy_c);

		rd_s3 <= rd_s2; x_s3 <= x_s2; y_s3 <= y_s2; rgb_s3 <= rgb_s2; in_s3 <= in_s2;
		nx_s3 <= nx_s2; ny_s3 <= ny_s2;
		r2_s3 <= sum_c[33:16];

		rd_s4 <= rd_s3; x_s4 <= x_s3; y_s4 <= y_s3; rgb_s4 <= rgb_s3; in_s4 <= in_s3;
		nx_s4 <= nx_s3; ny_s4 <= ny_s3;
		kr_s4 <= 34'(k) * 34'(r2_s3);
		vp_s4 <= 33'(r2_s3) * 33'(crt_bd_pkg::VIGNETTE_Q16);

		rd_s5 <= rd_s4; x_s5 <= x_s4; y_s5 <= y_s4; rgb_s5 <= rgb_s4; in_s5 <= in_s4;
		nx_s5 <= nx_s4; ny_s5 <= ny_s4;
		dt_s5 <= crt_bd_pkg::ONE_Q16 + kr_s4[33:16];
		// r2 is at most 2^17, so the weight never drops under zero
		vm_s5 <= 17'(crt_bd_pkg::ONE_Q16) - vp_s4[32:16];

		rd_s6 <= rd_s5; x_s6 <= x_s5; y_s6 <= y_s5; rgb_s6 <= rgb_s5; in_s6 <= in_s5;
		px_s6  <= nx_s5 * $signed({1'b0, dt_s5});
		py_s6  <= ny_s5 * $signed({1'b0, dt_s5});
		vm_s6  <= vm_s5;
		vsc_s6 <= 33'(vm_s5) * 33'(crt_bd_pkg::SCANLINE_Q16);

		rd_s7 <= rd_s6; x_s7 <= x_s6; y_s7 <= y_s6; rgb_s7 <= rgb_s6; in_s7 <= in_s6;
		ox_s7 <= sx_c + $signed({4'b0, crt_bd_pkg::ONE_Q16});
		oy_s7 <= sy_c + $signed({4'b0, crt_bd_pkg::ONE_Q16});
		// scanline darkening on odd rows
		vm_s7 <= y_s6[0] ? vsc_s6[32:16] : vm_s6;

		rd_s8 <= rd_s7; x_s8 <= x_s7; y_s8 <= y_s7; rgb_s8 <= rgb_s7; in_s8 <= in_s7;
		ux_s8 <= UXW'(ox_s7 * hw_c);
		uy_s8 <= UYW'(oy_s7 * hh_c);
		vm_s8 <= vm_s7;

		rd_s9 <= rd_s8; x_s9 <= x_s8; y_s9 <= y_s8; rgb_s9 <= rgb_s8;
		mp_s9  <= ok_c;
		sxa_s9 <= sxa_c;
		sya_s9 <= sya_c;
		vm_s9  <= vm_s8;

		mp_s10 <= mp_s9;
		vm_s10 <= vm_s9;

		mp_s11   <= mp_s10;
		vm_s11   <= vm_s10;
		luma_s11 <= luma_c;

		mp_s12 <= mp_s11;
		t1_s12 <= t1_c[40:16];

		mp_s13 <= mp_s12;
		t2_s13 <= t2_c[41:16];

		rsp_q.mapped <= mp_s13;
		if (!mp_s13) begin
			rsp_q.out_green <= 8'd0;
		end else if (t2_s13[25:24] != 2'b00) begin
			rsp_q.out_green <= 8'd255;
		end else begin
			rsp_q.out_green <= t2_s13[23:16];
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

### design/crt_barrel_distortion_filter_unit.sv
// ----------------------------------------------------------------------------
// crt_barrel_distortion_filter_unit
// crt look filter: frame store with barrel-distorted, vignetted green readout
// ----------------------------------------------------------------------------
// One transaction is taken in every cycle in which start is high and busy is
// low, writes and reads freely mixed. A read gives its result on rsp with done
// high for one cycle; results come in order and must be taken as they appear. A
// write gives no result. busy is high after reset and after each write of
// screen_width or screen_height, while a bit-serial divider forms the reciprocal
// of the clamped dimension one quotient bit per cycle. The frame store is one
// memory port shared by writes and reads in the same pipeline stage, which
// keeps their order.
module crt_barrel_distortion_filter_unit #(
	parameter int MAX_WIDTH  = crt_bd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = crt_bd_pkg::MAX_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  crt_bd_pkg::req_t                  req,
	output logic                              done,
	output crt_bd_pkg::rsp_t                  rsp,
	input  logic                              cfg_we,
	input  logic [crt_bd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [crt_bd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam int WCW = $clog2(MAX_WIDTH + 1);
	localparam int HCW = $clog2(MAX_HEIGHT + 1);

	logic [crt_bd_pkg::DIM_REG_W-1:0] width_q, height_q;
	logic [crt_bd_pkg::K_W-1:0]       k_q;
	logic                             pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= crt_bd_pkg::WIDTH_RESET;
			height_q <= crt_bd_pkg::HEIGHT_RESET;
			k_q      <= crt_bd_pkg::K_RESET;
			pend_q   <= 1'b1;
		end else begin
			pend_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_idx)
					crt_bd_pkg::CFG_SCREEN_WIDTH: begin
						width_q <= cfg_wdata[crt_bd_pkg::DIM_REG_W-1:0];
						pend_q  <= 1'b1;
					end
					crt_bd_pkg::CFG_SCREEN_HEIGHT: begin
						height_q <= cfg_wdata[crt_bd_pkg::DIM_REG_W-1:0];
						pend_q   <= 1'b1;
					end
					crt_bd_pkg::CFG_DISTORTION_K: begin
						k_q <= cfg_wdata[crt_bd_pkg::K_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// dimensions clamped to 2..max
	logic [WCW-1:0] w_c;
	logic [HCW-1:0] h_c;
	always_comb begin
		if (32'(width_q) < 32'd2) begin
			w_c = WCW'(2);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_c = WCW'(MAX_WIDTH);
		end else begin
			w_c = WCW'(width_q);
		end
		if (32'(height_q) < 32'd2) begin
			h_c = HCW'(2);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_c = HCW'(MAX_HEIGHT);
		end else begin
			h_c = HCW'(height_q);
		end
	end

	logic busy_x, busy_y;
	logic [crt_bd_pkg::INV_W-1:0] inv_x, inv_y;

	crt_bd_recip #(.DW(WCW)) u_recip_x (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (pend_q),
		.divisor(w_c),
		.busy   (busy_x),
		.quot   (inv_x)
	);

	crt_bd_recip #(.DW(HCW)) u_recip_y (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (pend_q),
		.divisor(h_c),
		.busy   (busy_y),
		.quot   (inv_y)
	);

	assign busy = pend_q | busy_x | busy_y;

	crt_bd_pipe #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.WCW       (WCW),
		.HCW       (HCW)
	) u_pipe (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(start & ~busy),
		.req   (req),
		.w     (w_c),
		.h     (h_c),
		.inv_x (inv_x),
		.inv_y (inv_y),
		.k     (k_q),
		.done  (done),
		.rsp   (rsp)
	);

endmodule

### test/crt_bd_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_bd_result_checker
// watches the request, config and result channels of the crt filter, keeps
// its own copy of the frame store and registers, predicts each read's green
// level and compares every result in order with the oldest expected one
// ----------------------------------------------------------------------------
module crt_bd_result_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  crt_bd_pkg::req_t                  req,
	input  logic                              done,
	input  crt_bd_pkg::rsp_t                  rsp,
	input  logic                              cfg_we,
	input  logic [crt_bd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [crt_bd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                                mismatches,
	output int                                pending
);
	import crt_bd_pkg::*;

	localparam longint Q1 = 65536;

	logic [23:0] pix_store [int];
	logic [DIM_REG_W-1:0] width_reg, height_reg;
	logic [K_W-1:0] k_reg;
	rsp_t green_q [$];

	function automatic longint clamp_dim(logic [DIM_REG_W-1:0] v, longint maxv);
		longint d;
		d = longint'(v);
		if (d < 2) d = 2;
		if (d > maxv) d = maxv;
		return d;
	endfunction

	// barrel map of one axis; returns -1 when the source leaves the screen
	function automatic longint warp_axis(longint n, longint dt, longint dim);
		longint p, s, u;
		p = n * dt;
		s = (p < 0) ? -((-p) >>> 16) : (p >>> 16);
		u = (s + Q1) * (dim >>> 1);
		if (u < 0 || u >= dim * Q1) return -1;
		return u >>> 16;
	endfunction

	function automatic rsp_t filter_pixel(longint x, longint y);
		rsp_t res;
		longint w, h, nx, ny, r2, dt, sx, sy, vm, luma, t;
		logic [23:0] rgb;
		res = '0;
		w = clamp_dim(width_reg, MAX_WIDTH_DEF);
		h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
		if (x >= w || y >= h) return res;
		nx = x * ((2 * Q1) / w) - Q1;
		ny = y * ((2 * Q1) / h) - Q1;
		r2 = (nx * nx + ny * ny) >>> 16;
		dt = Q1 + ((longint'(k_reg) * r2) >>> 16);
		sx = warp_axis(nx, dt, w);
		sy = warp_axis(ny, dt, h);
		if (sx < 0 || sy < 0) return res;
		rgb = pix_store.exists(int'(sy * 1024 + sx)) ? pix_store[int'(sy * 1024 + sx)] : '0;
		vm = Q1 - ((r2 * longint'(VIGNETTE_Q16)) >>> 16);
		if (vm < 0) vm = 0;
		if (y[0]) vm = (vm * longint'(SCANLINE_Q16)) >>> 16;
		luma = longint'(LUMA_R_Q16) * rgb[23:16] + longint'(LUMA_G_Q16) * rgb[15:8]
			+ longint'(LUMA_B_Q16) * rgb[7:0];
		t = (vm * luma) >>> 16;
		t = ((t * longint'(GAIN_Q16)) >>> 16) >>> 16;
		res.out_green = (t > 255) ? 8'd255 : t[7:0];
		res.mapped = 1'b1;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_r;
		if (!arst_n) begin
			width_reg  <= WIDTH_RESET;
			height_reg <= HEIGHT_RESET;
			k_reg      <= K_RESET;
			mismatches <= 0;
			green_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_SCREEN_WIDTH: width_reg <= cfg_wdata[DIM_REG_W-1:0];
					CFG_SCREEN_HEIGHT: height_reg <= cfg_wdata[DIM_REG_W-1:0];
					CFG_DISTORTION_K: k_reg <= cfg_wdata[K_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (req.req_type == REQ_WRITE)
					pix_store[int'(req.pixel_y) * 1024 + int'(req.pixel_x)] =
						{req.src_red, req.src_green, req.src_blue};
				else
					green_q.push_back(filter_pixel(req.pixel_x, req.pixel_y));
			end
			if (done) begin
				if (green_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual green %0d mapped %0b",
						$time, rsp.out_green, rsp.mapped);
					mismatches <= mismatches + 1;
				end else begin
					exp_r = green_q.pop_front();
					if (rsp.out_green !== exp_r.out_green || rsp.mapped !== exp_r.mapped) begin
						$display("%0t: mismatch, expected green %0d mapped %0b, actual green %0d mapped %0b",
							$time, exp_r.out_green, exp_r.mapped, rsp.out_green, rsp.mapped);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

	assign pending = green_q.size();
endmodule

### test/crt_barrel_distortion_filter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_barrel_distortion_filter_unit_tb
// drives writes that fill the active frame and reads across several screen
// sizes and distortion settings; a checker module predicts and compares
// ----------------------------------------------------------------------------
module crt_barrel_distortion_filter_unit_tb;
	import crt_bd_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int mismatches;
	int pending;
	int idle_pct;
	int act_w, act_h;

	crt_barrel_distortion_filter_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	crt_bd_result_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.mismatches(mismatches), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 600000);
		$display("status: fail");
		$finish;
	end

	// called at a falling edge; returns at the falling edge after acceptance, or later after a random idle gap
	task automatic send(logic kind, int x, int y, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		start <= 1'b1;
		req <= '{req_type: kind, pixel_x: x[9:0], pixel_y: y[9:0],
			src_red: r, src_green: g, src_blue: b};
		while (busy) @(negedge clk);
		@(negedge clk);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
	endtask

	task automatic pixel_write(int x, int y);
		send(REQ_WRITE, x, y, 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)));
	endtask

	// only between phases, with no read in flight and writes drained
	task automatic set_screen(int w, int h, int k);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_we <= 1'b1; cfg_idx <= CFG_SCREEN_WIDTH; cfg_wdata <= w[15:0];
		@(negedge clk);
		cfg_idx <= CFG_SCREEN_HEIGHT; cfg_wdata <= h[15:0];
		@(negedge clk);
		cfg_idx <= CFG_DISTORTION_K; cfg_wdata <= k[15:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		act_w = (w[10:0] < 2) ? 2 : (w[10:0] > 1024) ? 1024 : w[10:0];
		act_h = (h[10:0] < 2) ? 2 : (h[10:0] > 1024) ? 1024 : h[10:0];
	endtask

	task automatic fill_frame(bit white);
		for (int y = 0; y < act_h; y++)
			for (int x = 0; x < act_w; x++)
				if (white) send(REQ_WRITE, x, y, 8'hff, 8'hff, 8'hff);
				else pixel_write(x, y);
	endtask

	// left part of the active frame only
	task automatic fill_columns(int ncol);
		for (int y = 0; y < act_h; y++)
			for (int x = 0; x < ncol; x++)
				pixel_write(x, y);
	endtask

	task automatic random_traffic(int n);
		int x, y;
		repeat (n) begin
			if ($urandom_range(3) == 0) begin
				x = $urandom_range(1023);
				y = $urandom_range(1023);
			end else begin
				x = $urandom_range(act_w + 1);
				y = $urandom_range(act_h + 1);
				if (x > 1023) x = 1023;
				if (y > 1023) y = 1023;
			end
			if ($urandom_range(99) < 70)
				send(REQ_READ, x, y, 8'($urandom), 8'($urandom), 8'($urandom));
			else if ($urandom_range(3) == 0)
				pixel_write($urandom_range(1023), $urandom_range(1023));
			else pixel_write($urandom_range(act_w - 1), $urandom_range(act_h - 1));
		end
	endtask

	initial begin
		int wait_cycles;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_idx = CFG_SCREEN_WIDTH;
		cfg_wdata = '0;
		idle_pct = 18;
		act_w = 800;
		act_h = 600;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// reset geometry: store extremes and reads outside the active frame
		send(REQ_WRITE, 0, 0, 8'hff, 8'hff, 8'hff);
		send(REQ_WRITE, 1023, 1023, 8'h00, 8'h00, 8'h00);
		send(REQ_WRITE, 1023, 0, 8'haa, 8'h55, 8'haa);
		send(REQ_WRITE, 0, 1023, 8'h55, 8'haa, 8'h55);
		send(REQ_READ, 1023, 1023, 8'hff, 8'hff, 8'hff);
		send(REQ_READ, 800, 0, 8'h00, 8'h00, 8'h00);
		send(REQ_READ, 0, 600, 8'h00, 8'h00, 8'h00);
		send(REQ_READ, 799, 600, 8'h00, 8'h00, 8'h00);

		set_screen(16, 12, 9830);
		fill_frame(1'b0);
		send(REQ_READ, 0, 0, 8'h00, 8'h00, 8'h00);
		send(REQ_READ, 8, 6, 8'h00, 8'h00, 8'h00);
		send(REQ_READ, 8, 7, 8'h00, 8'h00, 8'h00);
		send(REQ_READ, 15, 11, 8'h00, 8'h00, 8'h00);
		send(REQ_READ, 16, 0, 8'h00, 8'h00, 8'h00);
		send(REQ_READ, 0, 12, 8'h00, 8'h00, 8'h00);
		random_traffic(300);

		// strongest distortion on a white frame: corners fall off, centre saturates
		idle_pct = 56;
		set_screen(0, 5, 65535);
		fill_frame(1'b1);
		random_traffic(100);

		// with k zero every read lands on its own pixel, so only filled columns are read
		set_screen(2047, 1, 0);
		fill_columns(64);
		repeat (100)
			send(REQ_READ, $urandom_range(63), $urandom_range(3), 8'h00, 8'h00, 8'h00);

		idle_pct = 0;
		set_screen(23, 17, $urandom_range(65535));
		fill_frame(1'b0);
		random_traffic(200);

		set_screen(2, 64, 9830);
		fill_frame(1'b0);
		random_traffic(100);
		start <= 1'b0;

		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 2000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (30) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
